[hdl/crv_pkg.sv]
// Shared constants, delay line tables and saturation helpers for the comb/allpass reverb.
package crv_pkg;

    // Audio and storage formats.
    localparam int SAMPLE_RATE = 44100;
    localparam int SAMPLE_W    = 16;
    localparam int MIX_W       = 16;
    localparam int STORE_W     = 24;
    localparam int GAIN_W      = 16;
    localparam int FRAC        = 15;

    // Shared multiplier operand and product widths.
    localparam int MULT_B_W = GAIN_W + 1;
    localparam int PROD_W   = STORE_W + MULT_B_W;

    // Unity in the Q1.15 mix format.
    localparam logic [MIX_W-1:0] MIX_ONE = MIX_W'(1) << FRAC;

    localparam int NCOMB = 8;
    localparam int NAP   = 4;

    // Comb delay lengths scaled to the sample rate, and their offsets in the comb memory.
    localparam int unsigned COMB_LEN [NCOMB] = '{
        1116 * SAMPLE_RATE / 44100, 1188 * SAMPLE_RATE / 44100,
        1277 * SAMPLE_RATE / 44100, 1356 * SAMPLE_RATE / 44100,
        1422 * SAMPLE_RATE / 44100, 1491 * SAMPLE_RATE / 44100,
        1557 * SAMPLE_RATE / 44100, 1617 * SAMPLE_RATE / 44100
    };
    localparam int unsigned COMB_OFF [NCOMB] = '{
        0,
        COMB_LEN[0],
        COMB_LEN[0] + COMB_LEN[1],
        COMB_LEN[0] + COMB_LEN[1] + COMB_LEN[2],
        COMB_LEN[0] + COMB_LEN[1] + COMB_LEN[2] + COMB_LEN[3],
        COMB_LEN[0] + COMB_LEN[1] + COMB_LEN[2] + COMB_LEN[3] + COMB_LEN[4],
        COMB_LEN[0] + COMB_LEN[1] + COMB_LEN[2] + COMB_LEN[3] + COMB_LEN[4]
            + COMB_LEN[5],
        COMB_LEN[0] + COMB_LEN[1] + COMB_LEN[2] + COMB_LEN[3] + COMB_LEN[4]
            + COMB_LEN[5] + COMB_LEN[6]
    };
    localparam int unsigned COMB_TOTAL = COMB_OFF[NCOMB-1] + COMB_LEN[NCOMB-1];

    // Comb feedback gains in Q1.15, from a room size of 0.85.
    localparam logic [GAIN_W-1:0] COMB_GAIN [NCOMB] = '{
        16'd27333, 16'd27015, 16'd26627, 16'd26287,
        16'd26007, 16'd25717, 16'd25442, 16'd25195
    };

    // Allpass delay lengths and offsets in the allpass memory.
    localparam int unsigned AP_LEN [NAP] = '{
        556 * SAMPLE_RATE / 44100, 441 * SAMPLE_RATE / 44100,
        341 * SAMPLE_RATE / 44100, 225 * SAMPLE_RATE / 44100
    };
    localparam int unsigned AP_OFF [NAP] = '{
        0,
        AP_LEN[0],
        AP_LEN[0] + AP_LEN[1],
        AP_LEN[0] + AP_LEN[1] + AP_LEN[2]
    };
    localparam int unsigned AP_TOTAL = AP_OFF[NAP-1] + AP_LEN[NAP-1];

    // Index widths; the longest comb is the last one, the longest allpass the first.
    localparam int COMB_POS_W = $clog2(COMB_LEN[NCOMB-1]);
    localparam int AP_POS_W   = $clog2(AP_LEN[0]);
    localparam int COMB_AW    = $clog2(COMB_TOTAL);
    localparam int AP_AW      = $clog2(AP_TOTAL);
    localparam int STAGE_W    = $clog2(NCOMB);
    localparam int AP_STAGE_W = $clog2(NAP);

    // Saturate a value two bits wider than a store word to the store range.
    function automatic logic signed [STORE_W-1:0] sat_store(
        input logic signed [STORE_W+1:0] v
    );
        logic signed [STORE_W-1:0] r;
        if ((v[STORE_W+1:STORE_W-1] == 3'b000) || (v[STORE_W+1:STORE_W-1] == 3'b111))
        begin
            r = v[STORE_W-1:0];
        end
        else if (v[STORE_W+1])
        begin
            r = {1'b1, {(STORE_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(STORE_W-1){1'b1}}};
        end
        return r;
    endfunction

    // Saturate the mixed result to the Q1.15 sample range.
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [STORE_W+2:0] v
    );
        logic signed [SAMPLE_W-1:0] r;
        if ((v[STORE_W+2:SAMPLE_W-1] == '0) || (v[STORE_W+2:SAMPLE_W-1] == '1))
        begin
            r = v[SAMPLE_W-1:0];
        end
        else if (v[STORE_W+2])
        begin
            r = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

[hdl/crv_if.sv]
// Valid/ready channel interfaces for the reverb input, result and configuration words.
interface crv_sample_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [crv_pkg::SAMPLE_W-1:0]    sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface crv_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [crv_pkg::SAMPLE_W-1:0]    sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface crv_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [crv_pkg::MIX_W-1:0]          wet_mix;

    modport source (output valid, output wet_mix, input ready);
    modport sink   (input valid, input wet_mix, output ready);
endinterface

[hdl/comb_allpass_reverb_core.sv]
// Reverb core: eight comb lines and four allpass stages around one shared multiplier.
// Words: a new input word is accepted only in the idle state, once the previous result
// has been loaded for output; the sequencer visits each delay line in turn, the comb
// lines through the single multiplier, and uses the one write port of each delay memory.
// Reset: positions return to zero, the wet mix to 8192, and every line reads as silent
// until it has wrapped once, so no clearing pass is needed and the core is ready at once.
module comb_allpass_reverb_core (
    input  logic                clk,
    input  logic                rst_n,
    crv_sample_if.sink          sample_ch,
    crv_result_if.source        result_ch,
    crv_cfg_if.sink             cfg_ch
);

    localparam int SUM_W = crv_pkg::STORE_W + 3;
    localparam int EXT_W = crv_pkg::STORE_W + 2;
    localparam int ACC_W = crv_pkg::PROD_W + 1;

    typedef enum logic [8:0] {
        S_IDLE = 9'b0_0000_0001,
        S_CMUL = 9'b0_0000_0010,
        S_CWR  = 9'b0_0000_0100,
        S_AVG  = 9'b0_0000_1000,
        S_ANV  = 9'b0_0001_0000,
        S_AOUT = 9'b0_0010_0000,
        S_MIXA = 9'b0_0100_0000,
        S_MIXB = 9'b0_1000_0000,
        S_MIXC = 9'b1_0000_0000
    } state_t;

    state_t                                 state_reg, state_next;
    logic [crv_pkg::STAGE_W-1:0]            stage_reg, stage_next;
    logic [crv_pkg::AP_STAGE_W-1:0]         ap_stage;

    logic [crv_pkg::MIX_W-1:0]              wet_reg;
    logic [crv_pkg::MIX_W-1:0]              mix_eff;
    logic [crv_pkg::MIX_W-1:0]              dry_gain;

    logic [crv_pkg::COMB_POS_W-1:0]         comb_pos_reg [crv_pkg::NCOMB];
    logic [crv_pkg::NCOMB-1:0]              comb_wrap_reg;
    logic [crv_pkg::AP_POS_W-1:0]           ap_pos_reg [crv_pkg::NAP];
    logic [crv_pkg::NAP-1:0]                ap_wrap_reg;

    logic signed [crv_pkg::SAMPLE_W-1:0]    x_reg;
    logic signed [SUM_W-1:0]                sum_reg;
    logic signed [SUM_W-1:0]                avg_wide;
    logic signed [crv_pkg::STORE_W-1:0]     a_reg;
    logic signed [crv_pkg::STORE_W-1:0]     nv_reg;
    logic signed [crv_pkg::PROD_W-1:0]      prod_reg;
    logic signed [crv_pkg::PROD_W-1:0]      prod_next;
    logic                                   prod_load;
    logic signed [ACC_W-1:0]                acc_reg;
    logic signed [crv_pkg::SAMPLE_W-1:0]    out_reg;
    logic                                   out_valid_reg;

    // Shared multiplier operands.
    logic signed [crv_pkg::STORE_W-1:0]     mult_a;
    logic signed [crv_pkg::MULT_B_W-1:0]    mult_b;

    // Comb delay memory.
    logic signed [crv_pkg::STORE_W-1:0]     comb_mem [crv_pkg::COMB_TOTAL];
    logic signed [crv_pkg::STORE_W-1:0]     comb_rdata_reg;
    logic                                   comb_zero_reg;
    logic                                   comb_re, comb_we;
    logic [crv_pkg::STAGE_W-1:0]            comb_rd_stage;
    logic [crv_pkg::COMB_AW-1:0]            comb_raddr, comb_waddr;
    logic signed [crv_pkg::STORE_W-1:0]     comb_d;
    logic signed [crv_pkg::PROD_W-1:0]      comb_prod_rnd;
    logic signed [crv_pkg::PROD_W-1:0]      comb_prod_shift;
    logic signed [EXT_W-1:0]                comb_wide;
    logic signed [crv_pkg::STORE_W-1:0]     comb_wdata;
    logic                                   comb_pos_last;

    // Allpass delay memory.
    logic signed [crv_pkg::STORE_W-1:0]     ap_mem [crv_pkg::AP_TOTAL];
    logic signed [crv_pkg::STORE_W-1:0]     ap_rdata_reg;
    logic                                   ap_zero_reg;
    logic                                   ap_re, ap_we;
    logic [crv_pkg::AP_STAGE_W-1:0]         ap_rd_stage;
    logic [crv_pkg::AP_AW-1:0]              ap_raddr, ap_waddr;
    logic signed [crv_pkg::STORE_W-1:0]     ap_d;
    logic signed [EXT_W-1:0]                ap_d_ext, ap_d_half, ap_nv_wide;
    logic signed [crv_pkg::STORE_W-1:0]     ap_nv;
    logic signed [EXT_W-1:0]                nv_ext, nv_half, ap_out_wide;
    logic signed [crv_pkg::STORE_W-1:0]     ap_out;
    logic                                   ap_pos_last;

    // Final mix.
    logic signed [ACC_W-1:0]                mix_total, mix_shift;
    logic signed [SUM_W-1:0]                mix_wide;

    logic                                   in_accept;
    logic                                   out_load;

    assign ap_stage  = stage_reg[crv_pkg::AP_STAGE_W-1:0];
    assign in_accept = sample_ch.valid && sample_ch.ready;

    // Handshake outputs.
    assign sample_ch.ready  = (state_reg == S_IDLE);
    assign cfg_ch.ready     = 1'b1;
    assign result_ch.valid  = out_valid_reg;
    assign result_ch.sample_out = out_reg;

    // Wet share clamped to unity, and the matching dry share.
    assign mix_eff  = (wet_reg > crv_pkg::MIX_ONE) ? crv_pkg::MIX_ONE : wet_reg;
    assign dry_gain = crv_pkg::MIX_ONE - mix_eff;

    // Comb read side: the next line is fetched while the current one is multiplied.
    assign comb_re       = in_accept
                        || ((state_reg == S_CMUL)
                            && (stage_reg != crv_pkg::STAGE_W'(crv_pkg::NCOMB - 1)));
    assign comb_rd_stage = (state_reg == S_IDLE) ? '0 : stage_reg + 1'b1;
    assign comb_raddr    = crv_pkg::COMB_AW'(crv_pkg::COMB_OFF[comb_rd_stage])
                         + crv_pkg::COMB_AW'(comb_pos_reg[comb_rd_stage]);
    assign comb_d        = comb_zero_reg ? '0 : comb_rdata_reg;

    // Comb write side: input plus rounded feedback product, saturated.
    assign comb_we         = (state_reg == S_CWR);
    assign comb_waddr      = crv_pkg::COMB_AW'(crv_pkg::COMB_OFF[stage_reg])
                           + crv_pkg::COMB_AW'(comb_pos_reg[stage_reg]);
    assign comb_prod_rnd   = prod_reg + (crv_pkg::PROD_W'(1) <<< (crv_pkg::FRAC - 1));
    assign comb_prod_shift = comb_prod_rnd >>> crv_pkg::FRAC;
    assign comb_wide       = EXT_W'(comb_prod_shift) + EXT_W'(x_reg);
    assign comb_wdata      = crv_pkg::sat_store(comb_wide);
    assign comb_pos_last   = (comb_pos_reg[stage_reg]
                              == crv_pkg::COMB_POS_W'(crv_pkg::COMB_LEN[stage_reg] - 1));

    // Average of the eight comb outputs, rounded.
    assign avg_wide = (sum_reg + SUM_W'(4)) >>> 3;

    // Allpass read side: the next stage is fetched as the current one finishes.
    assign ap_re       = (state_reg == S_AVG)
                      || ((state_reg == S_AOUT)
                          && (ap_stage != crv_pkg::AP_STAGE_W'(crv_pkg::NAP - 1)));
    assign ap_rd_stage = (state_reg == S_AVG) ? '0 : ap_stage + 1'b1;
    assign ap_raddr    = crv_pkg::AP_AW'(crv_pkg::AP_OFF[ap_rd_stage])
                       + crv_pkg::AP_AW'(ap_pos_reg[ap_rd_stage]);
    assign ap_d        = ap_zero_reg ? '0 : ap_rdata_reg;

    // Allpass stored value: input plus half the delayed value.
    assign ap_we       = (state_reg == S_ANV);
    assign ap_waddr    = crv_pkg::AP_AW'(crv_pkg::AP_OFF[ap_stage])
                       + crv_pkg::AP_AW'(ap_pos_reg[ap_stage]);
    assign ap_d_ext    = EXT_W'(ap_d);
    assign ap_d_half   = (ap_d_ext + EXT_W'(1)) >>> 1;
    assign ap_nv_wide  = EXT_W'(a_reg) + ap_d_half;
    assign ap_nv       = crv_pkg::sat_store(ap_nv_wide);
    assign ap_pos_last = (ap_pos_reg[ap_stage]
                          == crv_pkg::AP_POS_W'(crv_pkg::AP_LEN[ap_stage] - 1));

    // Allpass output: delayed value minus half the stored value.
    assign nv_ext      = EXT_W'(nv_reg);
    assign nv_half     = (nv_ext + EXT_W'(1)) >>> 1;
    assign ap_out_wide = ap_d_ext - nv_half;
    assign ap_out      = crv_pkg::sat_store(ap_out_wide);

    // Final mix: wet and dry products summed with the rounding term, then saturated.
    assign mix_total = acc_reg + ACC_W'(prod_reg);
    assign mix_shift = mix_total >>> crv_pkg::FRAC;
    assign mix_wide  = SUM_W'(mix_shift);
    assign out_load  = (state_reg == S_MIXC) && (!out_valid_reg || result_ch.ready);

    // Shared multiplier operand selection.
    always_comb
    begin
        mult_a    = '0;
        mult_b    = '0;
        prod_load = 1'b0;
        case (state_reg)
            S_CMUL:
            begin
                mult_a    = comb_d;
                mult_b    = crv_pkg::MULT_B_W'(crv_pkg::COMB_GAIN[stage_reg]);
                prod_load = 1'b1;
            end
            S_MIXA:
            begin
                mult_a    = a_reg;
                mult_b    = crv_pkg::MULT_B_W'(mix_eff);
                prod_load = 1'b1;
            end
            S_MIXB:
            begin
                mult_a    = crv_pkg::STORE_W'(x_reg);
                mult_b    = crv_pkg::MULT_B_W'(dry_gain);
                prod_load = 1'b1;
            end
            default:
            begin
                prod_load = 1'b0;
            end
        endcase
        prod_next = mult_a * mult_b;
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        stage_next = stage_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_CMUL;
                    stage_next = '0;
                end
            end
            S_CMUL:
            begin
                state_next = S_CWR;
            end
            S_CWR:
            begin
                if (stage_reg == crv_pkg::STAGE_W'(crv_pkg::NCOMB - 1))
                begin
                    state_next = S_AVG;
                    stage_next = '0;
                end
                else
                begin
                    state_next = S_CMUL;
                    stage_next = stage_reg + 1'b1;
                end
            end
            S_AVG:
            begin
                state_next = S_ANV;
            end
            S_ANV:
            begin
                state_next = S_AOUT;
            end
            S_AOUT:
            begin
                if (ap_stage == crv_pkg::AP_STAGE_W'(crv_pkg::NAP - 1))
                begin
                    state_next = S_MIXA;
                end
                else
                begin
                    state_next = S_ANV;
                    stage_next = stage_reg + 1'b1;
                end
            end
            S_MIXA:
            begin
                state_next = S_MIXB;
            end
            S_MIXB:
            begin
                state_next = S_MIXC;
            end
            S_MIXC:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers: sequencer, wet mix, positions, fill flags and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            stage_reg     <= '0;
            wet_reg       <= crv_pkg::MIX_W'(8192);
            comb_wrap_reg <= '0;
            ap_wrap_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < crv_pkg::NCOMB; i++)
            begin
                comb_pos_reg[i] <= '0;
            end
            for (int i = 0; i < crv_pkg::NAP; i++)
            begin
                ap_pos_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            stage_reg <= stage_next;
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                wet_reg <= cfg_ch.wet_mix;
            end
            if (comb_we)
            begin
                comb_pos_reg[stage_reg] <= comb_pos_last ? '0 : comb_pos_reg[stage_reg] + 1'b1;
                if (comb_pos_last)
                begin
                    comb_wrap_reg[stage_reg] <= 1'b1;
                end
            end
            if (ap_we)
            begin
                ap_pos_reg[ap_stage] <= ap_pos_last ? '0 : ap_pos_reg[ap_stage] + 1'b1;
                if (ap_pos_last)
                begin
                    ap_wrap_reg[ap_stage] <= 1'b1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_reg   <= sample_ch.sample_in;
            sum_reg <= '0;
        end
        if (prod_load)
        begin
            prod_reg <= prod_next;
        end
        if (state_reg == S_CMUL)
        begin
            sum_reg <= sum_reg + SUM_W'(comb_d);
        end
        if (state_reg == S_AVG)
        begin
            a_reg <= crv_pkg::STORE_W'(avg_wide);
        end
        if (state_reg == S_ANV)
        begin
            nv_reg <= ap_nv;
        end
        if (state_reg == S_AOUT)
        begin
            a_reg <= ap_out;
        end
        if (state_reg == S_MIXB)
        begin
            acc_reg <= ACC_W'(prod_reg) + (ACC_W'(1) <<< (crv_pkg::FRAC - 1));
        end
        if (out_load)
        begin
            out_reg <= crv_pkg::sat_sample(mix_wide);
        end
    end

    // Comb delay memory; a line that has not yet wrapped reads as silence.
    always_ff @(posedge clk)
    begin
        if (comb_we)
        begin
            comb_mem[comb_waddr] <= comb_wdata;
        end
        if (comb_re)
        begin
            comb_rdata_reg <= comb_mem[comb_raddr];
            comb_zero_reg  <= !comb_wrap_reg[comb_rd_stage];
        end
    end

    // Allpass delay memory, same scheme.
    always_ff @(posedge clk)
    begin
        if (ap_we)
        begin
            ap_mem[ap_waddr] <= ap_nv;
        end
        if (ap_re)
        begin
            ap_rdata_reg <= ap_mem[ap_raddr];
            ap_zero_reg  <= !ap_wrap_reg[ap_rd_stage];
        end
    end

    // An accepted word always starts the sequencer at the first comb line.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_CMUL) && (stage_reg == '0))
    else $error("sequencer did not start at the first comb line");

    // Comb positions stay inside their line when written.
    assert property (@(posedge clk) disable iff (!rst_n)
        comb_we |-> (int'(comb_pos_reg[stage_reg]) < int'(crv_pkg::COMB_LEN[stage_reg])))
    else $error("comb position outside its delay line");

    // Allpass positions stay inside their line when written.
    assert property (@(posedge clk) disable iff (!rst_n)
        ap_we |-> (int'(ap_pos_reg[ap_stage]) < int'(crv_pkg::AP_LEN[ap_stage])))
    else $error("allpass position outside its delay line");

    // A finished word waits in the last mix state while the previous one is unread.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MIXC) && out_valid_reg && !result_ch.ready)
            |=> (state_reg == S_MIXC) && $stable(out_reg))
    else $error("result overwritten before it was taken");

    // The sequencer state is always exactly one-hot.
    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
    else $error("sequencer state not one-hot");

endmodule
